@@ rtl/core/escape_time_fractal_iteration_core_assert.svh @@
// assertion macros shared by the escape-time fractal core
// no dependencies; each macro takes a label, clock, reset, condition pair and message
`ifndef ESCAPE_TIME_FRACTAL_ITERATION_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATION_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ETF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ETF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/etf_pkg.sv @@
// shared types and constants of the escape-time fractal core
// no dependencies; imported by every module of the block
package etf_pkg;

  // default geometry of the number format and pixel indices
  localparam int unsigned CoordBitsDefault      = 32;
  localparam int unsigned FractionBitsDefault   = 28;
  localparam int unsigned PixelIndexBitsDefault = 12;

  // configuration port
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned IterBits     = 16;
  localparam int unsigned PitchBits    = 31;

  localparam logic [CfgIndexBits-1:0] RegJuliaMode      = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegIterationLimit = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegLeftReal       = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegPitchReal      = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegTopImag        = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegPitchImag      = 3'd5;
  localparam logic [CfgIndexBits-1:0] RegSeedReal       = 3'd6;
  localparam logic [CfgIndexBits-1:0] RegSeedImag       = 3'd7;

  // reset values: view of [-2.5, 1.5] with step 2^-10, Q3.28
  localparam logic [IterBits-1:0]    IterationLimitReset = 16'd256;
  localparam logic [CfgDataBits-1:0] LeftRealReset       = 32'hD800_0000;
  localparam logic [PitchBits-1:0]   PitchRealReset      = 31'h0004_0000;
  localparam logic [CfgDataBits-1:0] TopImagReset        = 32'h1800_0000;
  localparam logic [PitchBits-1:0]   PitchImagReset      = 31'h0004_0000;
  localparam logic [CfgDataBits-1:0] SeedReset           = 32'h0000_0000;

  typedef struct packed {
    logic                   julia_mode;
    logic [IterBits-1:0]    iteration_limit;
    logic [CfgDataBits-1:0] left_real;
    logic [PitchBits-1:0]   pitch_real;
    logic [CfgDataBits-1:0] top_imag;
    logic [PitchBits-1:0]   pitch_imag;
    logic [CfgDataBits-1:0] seed_real;
    logic [CfgDataBits-1:0] seed_imag;
  } etf_cfg_t;

endpackage

@@ rtl/core/etf_cfg_regs.sv @@
// configuration register file of the escape-time fractal core
// depends on etf_pkg for register indexes, reset values and the config struct
module etf_cfg_regs
  import etf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output etf_cfg_t                cfg_o
);

  etf_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegJuliaMode:      cfg_d.julia_mode      = cfg_data_i[0];
        RegIterationLimit: cfg_d.iteration_limit = cfg_data_i[IterBits-1:0];
        RegLeftReal:       cfg_d.left_real       = cfg_data_i;
        RegPitchReal:      cfg_d.pitch_real      = cfg_data_i[PitchBits-1:0];
        RegTopImag:        cfg_d.top_imag        = cfg_data_i;
        RegPitchImag:      cfg_d.pitch_imag      = cfg_data_i[PitchBits-1:0];
        RegSeedReal:       cfg_d.seed_real       = cfg_data_i;
        RegSeedImag:       cfg_d.seed_imag       = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.julia_mode      <= 1'b0;
      cfg_q.iteration_limit <= IterationLimitReset;
      cfg_q.left_real       <= LeftRealReset;
      cfg_q.pitch_real      <= PitchRealReset;
      cfg_q.top_imag        <= TopImagReset;
      cfg_q.pitch_imag      <= PitchImagReset;
      cfg_q.seed_real       <= SeedReset;
      cfg_q.seed_imag       <= SeedReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/etf_mult_unit.sv @@
// shared signed multiplier with registered product and fixed-point rescale
// depends on etf_pkg for default widths
module etf_mult_unit
  import etf_pkg::*;
#(
  parameter int unsigned COORD_BITS    = CoordBitsDefault,
  parameter int unsigned FRACTION_BITS = FractionBitsDefault,
  localparam int unsigned OpBits       = (COORD_BITS > 32) ? COORD_BITS : 32,
  localparam int unsigned ProdBits     = 2 * OpBits
) (
  input  logic                         clk_i,
  input  logic signed [OpBits-1:0]     a_i,
  input  logic signed [OpBits-1:0]     b_i,
  output logic signed [ProdBits-1:0]   raw_o,
  output logic signed [COORD_BITS-1:0] fix_o
);

  localparam logic signed [ProdBits-1:0] CoordMax =
    $signed({{(ProdBits-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [ProdBits-1:0] CoordMin = ~CoordMax;

  logic signed [ProdBits-1:0] prod_q, prod_d;
  logic signed [ProdBits-1:0] shifted;
  logic signed [ProdBits-1:0] trunc;
  logic signed [ProdBits-1:0] sat;
  logic                       round_up;

  assign prod_d = ProdBits'(a_i) * ProdBits'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // truncate toward zero: floor shift, then step back up for negative inexact values; saturate to range
  always_comb begin
    shifted  = prod_q >>> FRACTION_BITS;
    round_up = prod_q[ProdBits-1] && (prod_q[FRACTION_BITS-1:0] != '0);
    trunc    = shifted + $signed({{(ProdBits-1){1'b0}}, round_up});
    if (trunc > CoordMax) begin
      sat = CoordMax;
    end else if (trunc < CoordMin) begin
      sat = CoordMin;
    end else begin
      sat = trunc;
    end
  end

  assign raw_o = prod_q;
  assign fix_o = sat[COORD_BITS-1:0];

endmodule

@@ rtl/core/escape_time_fractal_iteration_core.sv @@
// escape-time fractal core: maps a pixel to a complex point and iterates z = z^2 + c
// depends on etf_pkg, etf_cfg_regs, etf_mult_unit and the assertion macro header
//
//   channel  direction  handshake                payload
//   in       to core    in_valid_i / in_ready_o  column_i, row_i
//   out      from core  out_valid_o / out_ready_i iterations_o, inside_res_o
//   cfg      to core    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one shared multiplier does three products per iteration in S_SQX, S_SQY and S_TEST
// a pixel escaping after n full iterations reports an iteration count of n
// an inside pixel reports the iteration limit; the next word is taken back in S_IDLE
// in_ready_o is high only between pixels; the result register frees the sequencer early
// a full result register stalls the sequencer in its last step until out_ready_i
// reset is asynchronous and active low; config registers go to their reset view
`include "escape_time_fractal_iteration_core_assert.svh"

module escape_time_fractal_iteration_core
  import etf_pkg::*;
#(
  parameter int unsigned COORD_BITS       = CoordBitsDefault,
  parameter int unsigned FRACTION_BITS    = FractionBitsDefault,
  parameter int unsigned PIXEL_INDEX_BITS = PixelIndexBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [PIXEL_INDEX_BITS-1:0] column_i,
  input  logic [PIXEL_INDEX_BITS-1:0] row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [IterBits-1:0]         iterations_o,
  output logic                        inside_res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIndexBits-1:0]     cfg_index_i,
  input  logic [CfgDataBits-1:0]      cfg_data_i
);

  localparam int unsigned OpBits   = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int unsigned ProdBits = 2 * OpBits;
  localparam int unsigned MapBits  = PIXEL_INDEX_BITS + PitchBits;
  localparam int unsigned WideBits =
    ((COORD_BITS > MapBits + 1) ? COORD_BITS : MapBits + 1) + 2;

  localparam logic signed [WideBits-1:0] CoordMax =
    $signed({{(WideBits-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [WideBits-1:0] CoordMin = ~CoordMax;
  localparam logic [COORD_BITS:0] EscapeLimit = (COORD_BITS+1)'(4) << FRACTION_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PX   = 4'd1;
  localparam logic [3:0] S_PY   = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_SQX  = 4'd4;
  localparam logic [3:0] S_SQY  = 4'd5;
  localparam logic [3:0] S_TEST = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  function automatic logic signed [COORD_BITS-1:0] clamp_c(input logic signed [WideBits-1:0] v);
    logic signed [WideBits-1:0] r;
    if (v > CoordMax) begin
      r = CoordMax;
    end else if (v < CoordMin) begin
      r = CoordMin;
    end else begin
      r = v;
    end
    return r[COORD_BITS-1:0];
  endfunction

  etf_cfg_t cfg;

  logic [3:0] state_q, state_d;
  logic [PIXEL_INDEX_BITS-1:0] col_q, col_d, row_q, row_d;
  logic signed [COORD_BITS-1:0] px_q, px_d;
  logic signed [COORD_BITS-1:0] zx_q, zx_d, zy_q, zy_d, cx_q, cx_d, cy_q, cy_d;
  logic signed [COORD_BITS-1:0] zx2_q, zx2_d, zy2_q, zy2_d;
  logic [IterBits-1:0] iter_q, iter_d, iter_next;
  logic [IterBits-1:0] res_cnt_q, res_cnt_d;
  logic res_inside_q, res_inside_d;
  logic out_valid_q, out_valid_d;
  logic [IterBits-1:0] iterations_q, iterations_d;
  logic inside_q, inside_d;

  logic signed [OpBits-1:0]     mul_a, mul_b;
  logic signed [ProdBits-1:0]   prod_raw;
  logic signed [COORD_BITS-1:0] prod_fix;

  logic signed [WideBits-1:0]   map_sum;
  logic signed [COORD_BITS-1:0] map_pt;
  logic [COORD_BITS:0]          mag_sum;
  logic signed [COORD_BITS-1:0] cross2, diff;
  logic                         in_accept, out_free;

  logic                         iterating, out_inside, out_escape;
  logic [IterBits-1:0]          iter_limit;

  etf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etf_mult_unit #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mult_unit (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .raw_o (prod_raw),
    .fix_o (prod_fix)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_PX: begin
        mul_a = OpBits'(col_q);
        mul_b = OpBits'(cfg.pitch_real);
      end
      S_PY: begin
        mul_a = OpBits'(row_q);
        mul_b = OpBits'(cfg.pitch_imag);
      end
      S_SQX: begin
        mul_a = OpBits'(zx_q);
        mul_b = OpBits'(zx_q);
      end
      S_SQY: begin
        mul_a = OpBits'(zy_q);
        mul_b = OpBits'(zy_q);
      end
      default: begin
        mul_a = OpBits'(zx_q);
        mul_b = OpBits'(zy_q);
      end
    endcase
  end

  // point mapping: column adds to the left edge, row subtracts from the top edge
  always_comb begin
    if (state_q == S_PY) begin
      map_sum = WideBits'(clamp_c(WideBits'($signed(cfg.left_real))))
              + $signed(WideBits'(prod_raw[MapBits-1:0]));
    end else begin
      map_sum = WideBits'(clamp_c(WideBits'($signed(cfg.top_imag))))
              - $signed(WideBits'(prod_raw[MapBits-1:0]));
    end
    map_pt = clamp_c(map_sum);
  end

  // both squares are saturated and nonnegative
  assign mag_sum = {1'b0, zx2_q} + {1'b0, prod_fix};
  assign cross2  = clamp_c(WideBits'(prod_fix) + WideBits'(prod_fix));
  assign diff    = clamp_c(WideBits'(zx2_q) - WideBits'(zy2_q));
  assign iter_next = iter_q + IterBits'(1);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    px_d         = px_q;
    zx_d         = zx_q;
    zy_d         = zy_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    zx2_d        = zx2_q;
    zy2_d        = zy2_q;
    iter_d       = iter_q;
    res_cnt_d    = res_cnt_q;
    res_inside_d = res_inside_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    iterations_d = iterations_q;
    inside_d     = inside_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          col_d   = column_i;
          row_d   = row_i;
          state_d = S_PX;
        end
      end
      S_PX: begin
        state_d = S_PY;
      end
      S_PY: begin
        px_d    = map_pt;
        state_d = S_INIT;
      end
      S_INIT: begin
        if (cfg.julia_mode) begin
          zx_d = px_q;
          zy_d = map_pt;
          cx_d = clamp_c(WideBits'($signed(cfg.seed_real)));
          cy_d = clamp_c(WideBits'($signed(cfg.seed_imag)));
        end else begin
          zx_d = '0;
          zy_d = '0;
          cx_d = px_q;
          cy_d = map_pt;
        end
        iter_d = '0;
        if (cfg.iteration_limit == '0) begin
          res_cnt_d    = '0;
          res_inside_d = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_SQX;
        end
      end
      S_SQX: begin
        state_d = S_SQY;
      end
      S_SQY: begin
        zx2_d   = prod_fix;
        state_d = S_TEST;
      end
      S_TEST: begin
        zy2_d = prod_fix;
        if (mag_sum > EscapeLimit) begin
          res_cnt_d    = iter_q;
          res_inside_d = 1'b0;
          state_d      = S_DONE;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        zy_d   = clamp_c(WideBits'(cross2) + WideBits'(cy_q));
        zx_d   = clamp_c(WideBits'(diff) + WideBits'(cx_q));
        iter_d = iter_next;
        if (iter_next == cfg.iteration_limit) begin
          res_cnt_d    = iter_next;
          res_inside_d = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_SQX;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          iterations_d = res_cnt_q;
          inside_d     = res_inside_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    row_q        <= row_d;
    px_q         <= px_d;
    zx_q         <= zx_d;
    zy_q         <= zy_d;
    cx_q         <= cx_d;
    cy_q         <= cy_d;
    zx2_q        <= zx2_d;
    zy2_q        <= zy2_d;
    res_cnt_q    <= res_cnt_d;
    res_inside_q <= res_inside_d;
    iterations_q <= iterations_d;
    inside_q     <= inside_d;
  end

  assign out_valid_o  = out_valid_q;
  assign iterations_o = iterations_q;
  assign inside_res_o = inside_q;

  assign iterating  = (state_q == S_SQX) || (state_q == S_SQY) ||
                      (state_q == S_TEST) || (state_q == S_UPD);
  assign out_inside = out_valid_o && inside_res_o;
  assign out_escape = out_valid_o && !inside_res_o;
  assign iter_limit = cfg.iteration_limit;

  `ETF_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_accept, state_q == S_PX, "no start")
  `ETF_ASSERT_IMPL(a_iter_lim, clk_i, rst_ni, iterating, iter_q < iter_limit, "at limit")
  `ETF_ASSERT_IMPL(a_in_lim, clk_i, rst_ni, out_inside, iterations_o == iter_limit, "in count")
  `ETF_ASSERT_IMPL(a_esc_lim, clk_i, rst_ni, out_escape, iterations_o < iter_limit, "esc count")

endmodule
